### hw/rtl/fcvm_pkg.sv
package fcvm_pkg;

   // Position format and CORDIC depth
   localparam int POS_FRAC_BITS = 16;
   localparam int CORDIC_STEPS  = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int CIDX_W        = $clog2(CORDIC_ITERS);
   localparam int MOVE_SHIFT    = 38 - POS_FRAC_BITS;
   localparam int TRANS_SHIFT   = POS_FRAC_BITS - 2;

   // Angles in 1/128 degree
   localparam int YAW_FULL    = 46080;
   localparam int YAW_HALF    = 23040;
   localparam int YAW_QUARTER = 11520;
   localparam int PITCH_LIMIT = 11392;
   localparam int ONE_Q14     = 16384;
   localparam int MOD_STEPS   = 12;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

   // Shared multiplier widths
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 34;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Item kinds
   localparam logic [1:0] KIND_MOVE    = 2'd0;
   localparam logic [1:0] KIND_TURN    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_MOVE_SPEED  = 3'd0;
   localparam logic [2:0] CSR_TURN_SPEED  = 3'd1;
   localparam logic [2:0] CSR_START_YAW   = 3'd2;
   localparam logic [2:0] CSR_START_PITCH = 3'd3;
   localparam logic [2:0] CSR_START_X     = 3'd4;
   localparam logic [2:0] CSR_START_Y     = 3'd5;
   localparam logic [2:0] CSR_START_Z     = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MV_SPD,
      ST_MV_SCL,
      ST_MV_CTL,
      ST_MV_AX,
      ST_MV_UPD,
      ST_TN_YAW,
      ST_TN_PIT,
      ST_TN_PCL,
      ST_TN_MOD,
      ST_RS_LOAD,
      ST_CY_GO,
      ST_CY_WAIT,
      ST_CP_GO,
      ST_CP_WAIT,
      ST_BM0,
      ST_BM1,
      ST_BM2,
      ST_BM3,
      ST_BM4,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] sin_v;
      logic signed [15:0] cos_v;
   } cordic_res_type;

   // Arctangent of 2^-i in Q15 of 1/128 degree units, that is times 32768
   function automatic logic [27:0] atan_entry(input logic [4:0] idx);
      logic [27:0] v;
      case (idx)
         5'd0:    v = 28'd188743680;
         5'd1:    v = 28'd111421900;
         5'd2:    v = 28'd58872272;
         5'd3:    v = 28'd29884485;
         5'd4:    v = 28'd15000234;
         5'd5:    v = 28'd7507429;
         5'd6:    v = 28'd3754631;
         5'd7:    v = 28'd1877430;
         5'd8:    v = 28'd938729;
         5'd9:    v = 28'd469366;
         5'd10:   v = 28'd234683;
         5'd11:   v = 28'd117342;
         5'd12:   v = 28'd58671;
         5'd13:   v = 28'd29335;
         5'd14:   v = 28'd14668;
         5'd15:   v = 28'd7334;
         5'd16:   v = 28'd3667;
         5'd17:   v = 28'd1833;
         5'd18:   v = 28'd917;
         5'd19:   v = 28'd458;
         5'd20:   v = 28'd229;
         5'd21:   v = 28'd115;
         5'd22:   v = 28'd57;
         5'd23:   v = 28'd29;
         default: v = 28'd0;
      endcase
      return v;
   endfunction

   // Saturate to 32 bit signed
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

### hw/rtl/fcvm_mul.sv
module fcvm_mul
   import fcvm_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0] prod_ff
);

   logic signed [MUL_P_W-1:0] prod_in;

   // Form the product, register it for the next step
   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hw/rtl/fcvm_cordic.sv
module fcvm_cordic
   import fcvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [16:0] angle,
   output cordic_res_type     res
);

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic [CIDX_W-1:0]  i_ff, i_in;
   logic               busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic signed [17:0] a1, a2;
   logic               fold;
   logic signed [33:0] dx, dy, cr, sr;
   logic signed [31:0] at;
   logic signed [15:0] cc, sc;

   // Fold the angle into plus or minus a quarter turn
   always_comb begin
      a1 = (18'(angle) > 18'sd23040) ? 18'(angle) - 18'sd46080 : 18'(angle);
      fold = 1'b0;
      a2 = a1;
      if (a1 > 18'(YAW_QUARTER)) begin
         a2 = a1 - 18'(YAW_HALF);
         fold = 1'b1;
      end else if (a1 < -18'(YAW_QUARTER)) begin
         a2 = a1 + 18'(YAW_HALF);
         fold = 1'b1;
      end
   end

   // One rotation per cycle
   always_comb begin
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = 32'(atan_entry(5'(i_ff)));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = 32'(a2) <<< 15;
         i_in = '0;
         neg_in = fold;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         if (i_ff == CIDX_W'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            i_in = i_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
      neg_ff <= neg_in;
   end

   // Round to Q1.14, clamp, undo the fold
   always_comb begin
      cr = (x_ff + 34'sd32768) >>> 16;
      sr = (y_ff + 34'sd32768) >>> 16;
      if (cr > 34'(ONE_Q14)) cc = 16'(ONE_Q14);
      else if (cr < -34'(ONE_Q14)) cc = -16'(ONE_Q14);
      else cc = cr[15:0];
      if (sr > 34'(ONE_Q14)) sc = 16'(ONE_Q14);
      else if (sr < -34'(ONE_Q14)) sc = -16'(ONE_Q14);
      else sc = sr[15:0];
      res.done = done_ff;
      res.cos_v = neg_ff ? -cc : cc;
      res.sin_v = neg_ff ? -sc : sc;
   end

endmodule

### hw/rtl/fly_camera_view_matrix.sv
// Fly camera producing a look-at view matrix.
// Request channel (req_): one word per item; kind selects move (keys and
// frame time), turn (mouse deltas) or restart (start pose). req_stall is
// high while an item is in work; a word is taken when req_valid is high and
// req_stall is low.
// Result channel (rsp_): four words per item, rows 0..3 of the view matrix,
// each with the camera position; rsp_last marks row 3. A word is taken when
// rsp_valid is high and rsp_stall is low; a stalled word holds.
// Config port (csr_): index and data, always ready; write only while idle.
// A move scales the speed and steps each axis (plus a control step when
// key bit 7 is set); a turn and a restart take two 16-step CORDIC runs on
// one rotator, a turn also a 12-step modulo reduction; a single shared
// multiplier is passed by every product in turn. Rows follow, one row per
// cycle while rsp_stall is low.
// The next item is accepted in the cycle after row 3 is taken.
// Reset loads the default registers and the default pose: position zero,
// yaw 270 degrees, pitch zero.
module fly_camera_view_matrix
   import fcvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_key_mask,
   input  logic [15:0]        req_delta_time,
   input  logic signed [15:0] req_mouse_dx,
   input  logic signed [15:0] req_mouse_dy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row,
   output logic signed [31:0] rsp_m0,
   output logic signed [31:0] rsp_m1,
   output logic signed [31:0] rsp_m2,
   output logic signed [31:0] rsp_m3,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   state_type state_ff, state_in;

   logic [15:0]        move_speed_ff, turn_speed_ff, start_yaw_ff;
   logic signed [14:0] start_pitch_ff;
   logic signed [31:0] start_pos_ff [3];

   logic [7:0]         keys_ff;
   logic [15:0]        dt_ff;
   logic signed [15:0] mdx_ff, mdy_ff;

   logic signed [31:0] pos_ff [3];
   logic [15:0]        yaw_ff;
   logic signed [14:0] pitch_ff;
   logic signed [15:0] front_ff [3];
   logic signed [15:0] right_ff [3];
   logic signed [15:0] up_ff [3];
   logic signed [15:0] sy_ff, cy_ff, sp_ff, cp_ff;

   logic [32:0]        vel_ff;
   logic [1:0]         k_ff, r_ff;
   logic [3:0]         cnt_ff;
   logic [29:0]        mw_ff;
   logic signed [50:0] acc_ff;
   logic signed [31:0] trans_ff [3];

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   logic               cordic_start;
   logic signed [16:0] cordic_angle;
   cordic_res_type     cres;

   logic [32:0]        vs;
   logic signed [17:0] coef;
   logic signed [15:0] dot_vec;
   logic signed [MUL_P_W-1:0] rnd5, rnd_move;
   logic signed [15:0] m14;
   logic signed [31:0] tmp_yaw, tmp_pitch;
   logic [29:0]        lim, mw_next;
   logic signed [50:0] acc_sum, acc_sel, acc_rnd;
   logic signed [63:0] pos_sum;

   fcvm_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   fcvm_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (cordic_angle),
      .res   (cres)
   );

   // Shared arithmetic helpers
   always_comb begin
      vs = keys_ff[6] ? {prod[31:0], 1'b0} : {1'b0, prod[31:0]};
      coef = '0;
      if (keys_ff[0]) coef = coef + 18'(front_ff[k_ff]);
      if (keys_ff[1]) coef = coef - 18'(front_ff[k_ff]);
      if (keys_ff[2]) coef = coef - 18'(right_ff[k_ff]);
      if (keys_ff[3]) coef = coef + 18'(right_ff[k_ff]);
      if (keys_ff[4]) coef = coef - 18'(up_ff[k_ff]);
      if (keys_ff[5]) coef = coef + 18'(up_ff[k_ff]);
      case (r_ff)
         2'd0:    dot_vec = right_ff[k_ff];
         2'd1:    dot_vec = up_ff[k_ff];
         default: dot_vec = front_ff[k_ff];
      endcase
      rnd5 = (prod + MUL_P_W'(16)) >>> 5;
      rnd_move = (prod + (MUL_P_W'(1) <<< (MOVE_SHIFT - 1))) >>> MOVE_SHIFT;
      pos_sum = 64'(pos_ff[k_ff]) + 64'(rnd_move);
      m14 = 16'((prod + MUL_P_W'(8192)) >>> 14);
      tmp_yaw = 32'($signed({1'b0, yaw_ff})) + 32'(rnd5) + 32'(YAW_FULL * 2048);
      tmp_pitch = 32'(pitch_ff) + 32'(rnd5);
      lim = 30'(YAW_FULL) << cnt_ff;
      mw_next = (mw_ff >= lim) ? mw_ff - lim : mw_ff;
      acc_sum = acc_ff + 51'(prod);
      acc_sel = (r_ff == 2'd2) ? acc_sum : -acc_sum;
      acc_rnd = (acc_sel + (51'sd1 <<< (TRANS_SHIFT - 1))) >>> TRANS_SHIFT;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_MOVE:    state_in = ST_MV_SPD;
                  KIND_TURN:    state_in = ST_TN_YAW;
                  KIND_RESTART: state_in = ST_RS_LOAD;
                  default:      state_in = ST_DOT_MUL;
               endcase
            end
         end
         ST_MV_SPD:  state_in = ST_MV_SCL;
         ST_MV_SCL:  state_in = keys_ff[7] ? ST_MV_CTL : ST_MV_AX;
         ST_MV_CTL:  state_in = ST_MV_AX;
         ST_MV_AX:   state_in = ST_MV_UPD;
         ST_MV_UPD:  state_in = (k_ff == 2'd2) ? ST_DOT_MUL : ST_MV_AX;
         ST_TN_YAW:  state_in = ST_TN_PIT;
         ST_TN_PIT:  state_in = ST_TN_PCL;
         ST_TN_PCL:  state_in = ST_TN_MOD;
         ST_TN_MOD:  state_in = (cnt_ff == 4'd0) ? ST_CY_GO : ST_TN_MOD;
         ST_RS_LOAD: state_in = ST_CY_GO;
         ST_CY_GO:   state_in = ST_CY_WAIT;
         ST_CY_WAIT: state_in = cres.done ? ST_CP_GO : ST_CY_WAIT;
         ST_CP_GO:   state_in = ST_CP_WAIT;
         ST_CP_WAIT: state_in = cres.done ? ST_BM0 : ST_CP_WAIT;
         ST_BM0:     state_in = ST_BM1;
         ST_BM1:     state_in = ST_BM2;
         ST_BM2:     state_in = ST_BM3;
         ST_BM3:     state_in = ST_BM4;
         ST_BM4:     state_in = ST_DOT_MUL;
         ST_DOT_MUL: state_in = ST_DOT_ACC;
         ST_DOT_ACC: begin
            if (k_ff == 2'd2 && r_ff == 2'd2) state_in = ST_EMIT;
            else state_in = ST_DOT_MUL;
         end
         ST_EMIT: begin
            if (!rsp_stall && r_ff == 2'd3) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake, multiplier operands and CORDIC requests
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      csr_ready = 1'b1;
      mul_a = '0;
      mul_b = '0;
      cordic_start = 1'b0;
      cordic_angle = 17'($signed({1'b0, yaw_ff}));
      case (state_ff)
         ST_MV_SPD: begin
            mul_a = MUL_A_W'($signed({1'b0, move_speed_ff}));
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
         ST_MV_SCL: begin
            mul_a = MUL_A_W'(13107);
            mul_b = MUL_B_W'($signed({1'b0, vs}));
         end
         ST_MV_AX: begin
            mul_a = coef;
            mul_b = MUL_B_W'($signed({1'b0, vel_ff}));
         end
         ST_TN_YAW: begin
            mul_a = MUL_A_W'(mdx_ff);
            mul_b = MUL_B_W'($signed({1'b0, turn_speed_ff}));
         end
         ST_TN_PIT: begin
            mul_a = MUL_A_W'(mdy_ff);
            mul_b = MUL_B_W'($signed({1'b0, turn_speed_ff}));
         end
         ST_CY_GO: cordic_start = 1'b1;
         ST_CP_GO: begin
            cordic_start = 1'b1;
            cordic_angle = 17'(pitch_ff);
         end
         ST_BM0: begin
            mul_a = MUL_A_W'(cp_ff);
            mul_b = MUL_B_W'(cy_ff);
         end
         ST_BM1: begin
            mul_a = MUL_A_W'(cp_ff);
            mul_b = MUL_B_W'(sy_ff);
         end
         ST_BM2: begin
            mul_a = MUL_A_W'(cy_ff);
            mul_b = MUL_B_W'(sp_ff);
         end
         ST_BM3: begin
            mul_a = MUL_A_W'(sy_ff);
            mul_b = MUL_B_W'(sp_ff);
         end
         ST_DOT_MUL: begin
            mul_a = MUL_A_W'(dot_vec);
            mul_b = MUL_B_W'(pos_ff[k_ff]);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         move_speed_ff <= 16'd1280;
         turn_speed_ff <= 16'd2048;
         start_yaw_ff <= 16'd34560;
         start_pitch_ff <= '0;
         start_pos_ff[0] <= '0;
         start_pos_ff[1] <= '0;
         start_pos_ff[2] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOVE_SPEED:  move_speed_ff <= csr_data[15:0];
            CSR_TURN_SPEED:  turn_speed_ff <= csr_data[15:0];
            CSR_START_YAW:   start_yaw_ff <= csr_data[15:0];
            CSR_START_PITCH: start_pitch_ff <= csr_data[14:0];
            CSR_START_X:     start_pos_ff[0] <= csr_data;
            CSR_START_Y:     start_pos_ff[1] <= csr_data;
            CSR_START_Z:     start_pos_ff[2] <= csr_data;
            default:         start_pitch_ff <= start_pitch_ff;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Camera pose and basis
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
         yaw_ff <= 16'd34560;
         pitch_ff <= '0;
         front_ff[0] <= '0;
         front_ff[1] <= '0;
         front_ff[2] <= -16'(ONE_Q14);
         right_ff[0] <= 16'(ONE_Q14);
         right_ff[1] <= '0;
         right_ff[2] <= '0;
         up_ff[0] <= '0;
         up_ff[1] <= 16'(ONE_Q14);
         up_ff[2] <= '0;
      end else begin
         case (state_ff)
            ST_MV_UPD: pos_ff[k_ff] <= sat32(pos_sum);
            ST_TN_PCL: begin
               if (tmp_pitch > 32'(PITCH_LIMIT)) pitch_ff <= 15'(PITCH_LIMIT);
               else if (tmp_pitch < -32'(PITCH_LIMIT)) pitch_ff <= -15'(PITCH_LIMIT);
               else pitch_ff <= tmp_pitch[14:0];
            end
            ST_TN_MOD: begin
               if (cnt_ff == 4'd0) yaw_ff <= mw_next[15:0];
            end
            ST_RS_LOAD: begin
               pos_ff[0] <= start_pos_ff[0];
               pos_ff[1] <= start_pos_ff[1];
               pos_ff[2] <= start_pos_ff[2];
               yaw_ff <= (start_yaw_ff >= 16'(YAW_FULL)) ?
                         start_yaw_ff - 16'(YAW_FULL) : start_yaw_ff;
               if (start_pitch_ff > 15'(PITCH_LIMIT)) pitch_ff <= 15'(PITCH_LIMIT);
               else if (start_pitch_ff < -15'(PITCH_LIMIT)) pitch_ff <= -15'(PITCH_LIMIT);
               else pitch_ff <= start_pitch_ff;
            end
            ST_BM1: front_ff[0] <= m14;
            ST_BM2: front_ff[2] <= m14;
            ST_BM3: up_ff[0] <= -m14;
            ST_BM4: begin
               up_ff[2] <= -m14;
               up_ff[1] <= cp_ff;
               front_ff[1] <= sp_ff;
               right_ff[0] <= -sy_ff;
               right_ff[1] <= '0;
               right_ff[2] <= cy_ff;
            end
            default: pitch_ff <= pitch_ff;
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            keys_ff <= req_key_mask;
            dt_ff <= req_delta_time;
            mdx_ff <= req_mouse_dx;
            mdy_ff <= req_mouse_dy;
            k_ff <= '0;
            r_ff <= '0;
            acc_ff <= '0;
         end
         ST_MV_SCL: vel_ff <= vs;
         ST_MV_CTL: vel_ff <= 33'((prod + MUL_P_W'(32768)) >>> 16);
         ST_MV_UPD: k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
         ST_TN_PIT: mw_ff <= tmp_yaw[29:0];
         ST_TN_PCL: cnt_ff <= 4'(MOD_STEPS - 1);
         ST_TN_MOD: begin
            mw_ff <= mw_next;
            cnt_ff <= cnt_ff - 4'd1;
         end
         ST_CY_WAIT: begin
            sy_ff <= cres.sin_v;
            cy_ff <= cres.cos_v;
         end
         ST_CP_WAIT: begin
            sp_ff <= cres.sin_v;
            cp_ff <= cres.cos_v;
         end
         ST_DOT_ACC: begin
            if (k_ff == 2'd2) begin
               trans_ff[r_ff] <= sat32(64'(acc_rnd));
               acc_ff <= '0;
               k_ff <= '0;
               r_ff <= (r_ff == 2'd2) ? 2'd0 : r_ff + 2'd1;
            end else begin
               acc_ff <= acc_sum;
               k_ff <= k_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) r_ff <= r_ff + 2'd1;
         end
         default: keys_ff <= keys_ff;
      endcase
   end

   // Result word from the stored rows
   always_comb begin
      rsp_row = r_ff;
      rsp_last = (r_ff == 2'd3);
      rsp_pos_x = pos_ff[0];
      rsp_pos_y = pos_ff[1];
      rsp_pos_z = pos_ff[2];
      case (r_ff)
         2'd0: begin
            rsp_m0 = 32'(right_ff[0]) <<< 2;
            rsp_m1 = 32'(right_ff[1]) <<< 2;
            rsp_m2 = 32'(right_ff[2]) <<< 2;
            rsp_m3 = trans_ff[0];
         end
         2'd1: begin
            rsp_m0 = 32'(up_ff[0]) <<< 2;
            rsp_m1 = 32'(up_ff[1]) <<< 2;
            rsp_m2 = 32'(up_ff[2]) <<< 2;
            rsp_m3 = trans_ff[1];
         end
         2'd2: begin
            rsp_m0 = -(32'(front_ff[0]) <<< 2);
            rsp_m1 = -(32'(front_ff[1]) <<< 2);
            rsp_m2 = -(32'(front_ff[2]) <<< 2);
            rsp_m3 = trans_ff[2];
         end
         default: begin
            rsp_m0 = '0;
            rsp_m1 = '0;
            rsp_m2 = '0;
            rsp_m3 = 32'sd65536;
         end
      endcase
   end

endmodule
